[design/orhm_pkg.sv]
// Shared types and constants of the order rate health monitor.
// Used by every module under design/; depends on nothing else.
package orhm_pkg;

    // Time width default for the top-level parameter (32 to 64)
    localparam int TIME_BITS_DEF = 64;

    // One second in nanoseconds; fits in 30 bits for the shared multiplier
    localparam logic [63:0] NS_PER_SEC = 64'd1_000_000_000;
    localparam int          NS_BITS    = 30;

    // Benchmark check period and trip count
    localparam int          CHECK_PERIOD = 1000;
    localparam int          PHASE_BITS   = $clog2(CHECK_PERIOD);
    localparam logic [PHASE_BITS-1:0] PHASE_LAST = PHASE_BITS'(CHECK_PERIOD - 1);
    localparam logic [1:0]  BREACH_TRIP  = 2'd3;

    // Divider: one quotient bit per step
    localparam int DIV_STEPS = 64;
    localparam int STEP_BITS = $clog2(DIV_STEPS);

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

    // Action codes
    localparam logic ACT_ORDER    = 1'b0;
    localparam logic ACT_FINALIZE = 1'b1;

    // Stop reasons
    localparam logic [2:0] STOP_RUNNING  = 3'd0;
    localparam logic [2:0] STOP_FINALIZE = 3'd1;
    localparam logic [2:0] STOP_OVERFLOW = 3'd2;
    localparam logic [2:0] STOP_SLA      = 3'd3;
    localparam logic [2:0] STOP_HEALTH   = 3'd4;

    // Configuration register indexes
    localparam int CFG_INDEX_BITS = 3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_BENCHMARK_MODE   = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_MAX_QUEUE_DEPTH  = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SLA_LIMIT        = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_BENCH_QUEUE      = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_BENCH_LATENCY    = 3'd4;
    localparam int CFG_DATA_BITS = 32;

    // Configuration reset values
    localparam logic [23:0] MAX_QUEUE_DEPTH_RST   = 24'd1048576;
    localparam logic [31:0] SLA_LIMIT_RST         = 32'd1000000;
    localparam logic [23:0] BENCH_QUEUE_RST       = 24'd65536;
    localparam logic [31:0] BENCH_LATENCY_RST     = 32'd1000000;

    typedef struct packed {
        logic        action;
        logic [23:0] queue_depth;
        logic [63:0] start_ns;
        logic [63:0] end_ns;
    } order_t;

    typedef struct packed {
        logic [2:0]  stop_reason;
        logic        queue_breach;
        logic        latency_breach;
        logic [63:0] peak_rate;
        logic [63:0] active_span_ns;
        logic        item_ignored;
    } result_t;

    // Classified item handed from front to back; times already masked
    typedef struct packed {
        logic        action;
        logic        bench;
        logic        over_depth;
        logic        over_sla;
        logic        bench_q;
        logic        bench_l;
        logic [63:0] start_ns;
        logic [63:0] end_ns;
    } cls_item_t;

    typedef struct packed {
        logic        start;
        logic [63:0] count;
        logic [63:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] quotient;
    } div_rsp_t;

endpackage

[design/orhm_front.sv]
// Front end: configuration registers and classification of incoming orders.
// Depends on orhm_pkg.
module orhm_front #(
    parameter int TIME_BITS = orhm_pkg::TIME_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [orhm_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [orhm_pkg::CFG_DATA_BITS-1:0]    cfg_data,
    input  logic                                  order_valid,
    output logic                                  order_ready,
    input  orhm_pkg::order_t                      order,
    output logic                                  push_valid,
    input  logic                                  push_ready,
    output orhm_pkg::cls_item_t                   push_item
);

    logic        bench_mode_reg;
    logic [23:0] max_depth_reg;
    logic [31:0] sla_limit_reg;
    logic [23:0] bench_queue_reg;
    logic [31:0] bench_latency_reg;

    logic [TIME_BITS-1:0] t0;
    logic [TIME_BITS-1:0] t1;
    logic [TIME_BITS-1:0] dur;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bench_mode_reg    <= 1'b0;
            max_depth_reg     <= orhm_pkg::MAX_QUEUE_DEPTH_RST;
            sla_limit_reg     <= orhm_pkg::SLA_LIMIT_RST;
            bench_queue_reg   <= orhm_pkg::BENCH_QUEUE_RST;
            bench_latency_reg <= orhm_pkg::BENCH_LATENCY_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                orhm_pkg::REG_BENCHMARK_MODE:  bench_mode_reg    <= cfg_data[0];
                orhm_pkg::REG_MAX_QUEUE_DEPTH: max_depth_reg     <= cfg_data[23:0];
                orhm_pkg::REG_SLA_LIMIT:       sla_limit_reg     <= cfg_data;
                orhm_pkg::REG_BENCH_QUEUE:     bench_queue_reg   <= cfg_data[23:0];
                orhm_pkg::REG_BENCH_LATENCY:   bench_latency_reg <= cfg_data;
                default:                       ;
            endcase
        end
    end

    // Latency wraps modulo the time width
    assign t0  = order.start_ns[TIME_BITS-1:0];
    assign t1  = order.end_ns[TIME_BITS-1:0];
    assign dur = t1 - t0;

    assign order_ready = push_ready;
    assign push_valid  = order_valid;

    always_comb
    begin
        push_item.action     = order.action;
        push_item.bench      = bench_mode_reg;
        push_item.over_depth = order.queue_depth > max_depth_reg;
        push_item.over_sla   = dur > TIME_BITS'(sla_limit_reg);
        push_item.bench_q    = order.queue_depth > bench_queue_reg;
        push_item.bench_l    = dur > TIME_BITS'(bench_latency_reg);
        push_item.start_ns   = 64'(t0);
        push_item.end_ns     = 64'(t1);
    end

endmodule

[design/orhm_queue.sv]
// Short queue of classified items between front and back.
// Depends on orhm_pkg.
module orhm_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push_valid,
    output logic                push_ready,
    input  orhm_pkg::cls_item_t push_item,
    output logic                pop_valid,
    input  logic                pop_ready,
    output orhm_pkg::cls_item_t pop_item
);

    orhm_pkg::cls_item_t entry_reg [orhm_pkg::QUEUE_DEPTH];

    logic [orhm_pkg::QPTR_BITS-1:0] wr_ptr_reg;
    logic [orhm_pkg::QPTR_BITS-1:0] rd_ptr_reg;
    logic [orhm_pkg::QPTR_BITS:0]   fill_reg;
    logic                           push_fire;
    logic                           pop_fire;

    assign push_ready = fill_reg != (orhm_pkg::QPTR_BITS + 1)'(orhm_pkg::QUEUE_DEPTH);
    assign pop_valid  = fill_reg != '0;
    assign push_fire  = push_valid && push_ready;
    assign pop_fire   = pop_valid && pop_ready;
    assign pop_item   = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push_fire)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    // Depth is a power of two, so the pointers wrap on their own
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push_fire)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop_fire)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push_fire && !pop_fire)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            else if (pop_fire && !push_fire)
            begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

endmodule

[design/orhm_rate_div.sv]
// Rate unit: floor(count * 1e9 / elapsed) by a shared 32x30 multiplier
// and a restoring divider, one quotient bit per cycle. Depends on orhm_pkg.
module orhm_rate_div (
    input  logic                clk,
    input  logic                rst_n,
    input  orhm_pkg::div_req_t  req,
    output orhm_pkg::div_rsp_t  rsp
);

    typedef enum logic [4:0] {
        D_IDLE   = 5'b00001,
        D_MUL_LO = 5'b00010,
        D_MUL_HI = 5'b00100,
        D_ADD    = 5'b01000,
        D_DIV    = 5'b10000
    } div_state_t;

    div_state_t state_reg;
    logic       done_reg;

    logic [63:0] count_reg;
    logic [63:0] divisor_reg;
    logic [61:0] p0_reg;
    logic [61:0] p1_reg;
    logic [63:0] rem_reg;
    logic [63:0] lo_reg;
    logic [63:0] quo_reg;
    logic [orhm_pkg::STEP_BITS-1:0] step_reg;

    logic [31:0] mul_a;
    logic [61:0] mul_p;
    logic [93:0] wide_sum;
    logic [63:0] shifted;
    logic        take;

    assign mul_a    = (state_reg == D_MUL_LO) ? count_reg[31:0] : count_reg[63:32];
    assign mul_p    = 62'(mul_a) * 62'(orhm_pkg::NS_PER_SEC[orhm_pkg::NS_BITS-1:0]);
    assign wide_sum = {p1_reg, 32'd0} + 94'(p0_reg);

    // A set top bit means the shifted remainder exceeds 64 bits: always subtract
    assign shifted = {rem_reg[62:0], lo_reg[63]};
    assign take    = rem_reg[63] || (shifted >= divisor_reg);

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            D_IDLE:
            begin
                if (req.start)
                begin
                    count_reg   <= req.count;
                    divisor_reg <= req.divisor;
                end
            end
            D_MUL_LO: p0_reg <= mul_p;
            D_MUL_HI: p1_reg <= mul_p;
            D_ADD:
            begin
                rem_reg <= 64'(wide_sum[93:64]);
                lo_reg  <= wide_sum[63:0];
            end
            D_DIV:
            begin
                rem_reg <= take ? (shifted - divisor_reg) : shifted;
                lo_reg  <= {lo_reg[62:0], 1'b0};
                quo_reg <= {quo_reg[62:0], take};
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            done_reg  <= 1'b0;
            step_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                D_IDLE:
                begin
                    if (req.start)
                    begin
                        state_reg <= D_MUL_LO;
                    end
                end
                D_MUL_LO: state_reg <= D_MUL_HI;
                D_MUL_HI: state_reg <= D_ADD;
                D_ADD:
                begin
                    step_reg  <= orhm_pkg::STEP_BITS'(orhm_pkg::DIV_STEPS - 1);
                    state_reg <= D_DIV;
                end
                D_DIV:
                begin
                    step_reg <= step_reg - 1'b1;
                    if (step_reg == '0)
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= D_IDLE;
                    end
                end
                default: state_reg <= D_IDLE;
            endcase
        end
    end

endmodule

[design/orhm_back.sv]
// Back end: breaker state, span, benchmark checks, rate windows and the
// result register. Depends on orhm_pkg; drives the orhm_rate_div request.
module orhm_back #(
    parameter int TIME_BITS = orhm_pkg::TIME_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                pop_valid,
    output logic                pop_ready,
    input  orhm_pkg::cls_item_t pop_item,
    output orhm_pkg::div_req_t  div_req,
    input  orhm_pkg::div_rsp_t  div_rsp,
    output logic                result_valid,
    input  logic                result_ready,
    output orhm_pkg::result_t   result
);

    typedef enum logic [2:0] {
        B_RUN  = 3'b001,
        B_WAIT = 3'b010,
        B_FIN  = 3'b100
    } back_state_t;

    back_state_t state_reg;

    logic [2:0]                     stopped_reg, stopped_next;
    logic                           span_valid_reg, span_valid_next;
    logic [TIME_BITS-1:0]           first_reg, first_next;
    logic [TIME_BITS-1:0]           last_reg, last_next;
    logic [orhm_pkg::PHASE_BITS-1:0] phase_reg, phase_next;
    logic [1:0]                     run_reg, run_next;
    logic [1:0]                     flags_reg, flags_next;
    logic [TIME_BITS-1:0]           win_start_reg, win_start_next;
    logic [63:0]                    win_orders_reg, win_orders_next;
    logic [63:0]                    best_reg;
    logic                           ignored_reg;
    logic                           out_valid_reg;
    orhm_pkg::result_t              out_reg;

    logic [TIME_BITS-1:0]           t0;
    logic [TIME_BITS-1:0]           t1;
    logic [TIME_BITS-1:0]           el_last;
    logic [TIME_BITS-1:0]           el_t1;
    logic                           win_open;
    logic                           full_last;
    logic                           full_t1;
    logic [orhm_pkg::PHASE_BITS-1:0] phase_inc;
    logic [1:0]                     run_inc;
    logic [63:0]                    orders_inc;
    logic                           ignored;
    logic                           tripped;
    logic                           need_div;
    logic [TIME_BITS-1:0]           close_el;
    logic [63:0]                    close_cnt;
    logic                           out_free;
    logic                           pop_fire;
    logic [TIME_BITS-1:0]           span_new;
    logic [TIME_BITS-1:0]           span_cur;
    logic [63:0]                    best_max;

    assign t0 = pop_item.start_ns[TIME_BITS-1:0];
    assign t1 = pop_item.end_ns[TIME_BITS-1:0];

    // Both possible window closes, computed side by side
    assign el_last   = last_reg - win_start_reg;
    assign el_t1     = t1 - win_start_reg;
    assign win_open  = win_start_reg != '0;
    assign full_last = win_open && (64'(el_last) >= orhm_pkg::NS_PER_SEC);
    assign full_t1   = win_open && (64'(el_t1) >= orhm_pkg::NS_PER_SEC);

    assign phase_inc  = (phase_reg == orhm_pkg::PHASE_LAST) ? '0 : phase_reg + 1'b1;
    assign run_inc    = (run_reg < orhm_pkg::BREACH_TRIP) ? run_reg + 2'd1 : run_reg;
    assign orders_inc = win_orders_reg + 64'd1;
    assign ignored    = stopped_reg != orhm_pkg::STOP_RUNNING;

    always_comb
    begin
        stopped_next    = stopped_reg;
        span_valid_next = span_valid_reg;
        first_next      = first_reg;
        last_next       = last_reg;
        phase_next      = phase_reg;
        run_next        = run_reg;
        flags_next      = flags_reg;
        win_start_next  = win_start_reg;
        win_orders_next = win_orders_reg;
        tripped         = 1'b0;
        need_div        = 1'b0;
        close_el        = el_t1;
        close_cnt       = win_orders_reg;

        if (!ignored)
        begin
            if (pop_item.action == orhm_pkg::ACT_FINALIZE)
            begin
                stopped_next = orhm_pkg::STOP_FINALIZE;
                need_div     = span_valid_reg && full_last;
                close_el     = el_last;
            end
            else if (!pop_item.bench && pop_item.over_depth)
            begin
                // Overflowing order is dropped before it is recorded
                stopped_next = orhm_pkg::STOP_OVERFLOW;
                need_div     = span_valid_reg && full_last;
                close_el     = el_last;
            end
            else
            begin
                if (!span_valid_reg)
                begin
                    first_next      = t0;
                    span_valid_next = 1'b1;
                end
                last_next = t1;

                if (pop_item.bench)
                begin
                    phase_next = phase_inc;
                    if (phase_inc == '0)
                    begin
                        flags_next = {pop_item.bench_l, pop_item.bench_q};
                        if (pop_item.bench_q || pop_item.bench_l)
                        begin
                            run_next = run_inc;
                            if (run_inc >= orhm_pkg::BREACH_TRIP)
                            begin
                                stopped_next = orhm_pkg::STOP_HEALTH;
                                tripped      = 1'b1;
                                need_div     = full_t1;
                            end
                        end
                        else
                        begin
                            run_next = '0;
                        end
                    end
                end
                else if (pop_item.over_sla)
                begin
                    stopped_next = orhm_pkg::STOP_SLA;
                    tripped      = 1'b1;
                    need_div     = full_t1;
                end

                // Count the order; a full second since window start closes it
                if (!tripped)
                begin
                    if (full_t1)
                    begin
                        need_div        = 1'b1;
                        close_cnt       = orders_inc;
                        win_start_next  = t1;
                        win_orders_next = '0;
                    end
                    else
                    begin
                        win_start_next  = win_open ? win_start_reg : t1;
                        win_orders_next = orders_inc;
                    end
                end
            end
        end
    end

    assign out_free = !out_valid_reg || result_ready;
    assign pop_ready = (state_reg == B_RUN) && out_free;
    assign pop_fire  = pop_valid && pop_ready;

    assign div_req.start   = pop_fire && need_div;
    assign div_req.count   = close_cnt;
    assign div_req.divisor = 64'(close_el);

    assign span_new = span_valid_next ? (last_next - first_next) : '0;
    assign span_cur = span_valid_reg ? (last_reg - first_reg) : '0;
    assign best_max = (div_rsp.quotient > best_reg) ? div_rsp.quotient : best_reg;

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    always_ff @(posedge clk)
    begin
        if (pop_fire && !need_div)
        begin
            out_reg.stop_reason    <= stopped_next;
            out_reg.queue_breach   <= flags_next[0];
            out_reg.latency_breach <= flags_next[1];
            out_reg.peak_rate      <= best_reg;
            out_reg.active_span_ns <= 64'(span_new);
            out_reg.item_ignored   <= ignored;
        end
        else if (state_reg == B_FIN && out_free)
        begin
            out_reg.stop_reason    <= stopped_reg;
            out_reg.queue_breach   <= flags_reg[0];
            out_reg.latency_breach <= flags_reg[1];
            out_reg.peak_rate      <= best_max;
            out_reg.active_span_ns <= 64'(span_cur);
            out_reg.item_ignored   <= ignored_reg;
        end
        if (pop_fire)
        begin
            ignored_reg <= ignored;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= B_RUN;
            out_valid_reg  <= 1'b0;
            stopped_reg    <= orhm_pkg::STOP_RUNNING;
            span_valid_reg <= 1'b0;
            first_reg      <= '0;
            last_reg       <= '0;
            phase_reg      <= '0;
            run_reg        <= '0;
            flags_reg      <= '0;
            win_start_reg  <= '0;
            win_orders_reg <= '0;
            best_reg       <= '0;
        end
        else
        begin
            if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                B_RUN:
                begin
                    if (pop_fire)
                    begin
                        stopped_reg    <= stopped_next;
                        span_valid_reg <= span_valid_next;
                        first_reg      <= first_next;
                        last_reg       <= last_next;
                        phase_reg      <= phase_next;
                        run_reg        <= run_next;
                        flags_reg      <= flags_next;
                        win_start_reg  <= win_start_next;
                        win_orders_reg <= win_orders_next;
                        if (need_div)
                        begin
                            state_reg <= B_WAIT;
                        end
                        else
                        begin
                            out_valid_reg <= 1'b1;
                        end
                    end
                end
                B_WAIT:
                begin
                    if (div_rsp.done)
                    begin
                        state_reg <= B_FIN;
                    end
                end
                B_FIN:
                begin
                    // Hold the quotient until the result slot frees up
                    if (out_free)
                    begin
                        best_reg      <= best_max;
                        out_valid_reg <= 1'b1;
                        state_reg     <= B_RUN;
                    end
                end
                default: state_reg <= B_RUN;
            endcase
        end
    end

endmodule

[design/order_rate_health_monitor.sv]
// Top level of the order rate health monitor: front, queue, back, rate unit.
// Depends on orhm_pkg, orhm_front, orhm_queue, orhm_back, orhm_rate_div.
//
//   Channel  | Handshake                  | Payload
//   ---------+----------------------------+------------------------------------
//   order    | order_valid / order_ready  | orhm_pkg::order_t (one order event)
//   result   | result_valid / result_ready| orhm_pkg::result_t (one per order)
//   cfg      | cfg_valid / cfg_ready      | cfg_index, cfg_data (register write)
//
// An order that closes no full one-second window is taken and registered as
// its result directly, so such orders sustain one transfer per cycle while
// result_ready is not held low. An order that closes a window (rollover,
// trip, overflow or finalize with a window open a full second) holds the back
// end for a low and high multiply, an add and 64 bit-serial divider steps.
// The two-entry queue keeps the order channel open while the back end works.
// Reset (rst_n, asynchronous, active low) clears all breaker, span, check
// and window state and loads the configuration defaults; cfg_ready is
// always high. A stalled result holds in the result register and stalls the
// back end, and the front only once the queue is full.
module order_rate_health_monitor #(
    parameter int TIME_BITS = orhm_pkg::TIME_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [orhm_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [orhm_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                                order_valid,
    output logic                                order_ready,
    input  orhm_pkg::order_t                    order,
    output logic                                result_valid,
    input  logic                                result_ready,
    output orhm_pkg::result_t                   result
);

    // Front to queue
    logic                push_valid;
    logic                push_ready;
    orhm_pkg::cls_item_t push_item;

    // Queue to back
    logic                pop_valid;
    logic                pop_ready;
    orhm_pkg::cls_item_t pop_item;

    // Back to rate unit
    orhm_pkg::div_req_t  div_req;
    orhm_pkg::div_rsp_t  div_rsp;

    // Hold configuration and classify each order against the limits
    orhm_front #(
        .TIME_BITS (TIME_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .order_valid (order_valid),
        .order_ready (order_ready),
        .order       (order),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_item   (push_item)
    );

    // Decouple the front from back-end stalls
    orhm_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    // Advance breaker state and build one result per transfer
    orhm_back #(
        .TIME_BITS (TIME_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .pop_valid    (pop_valid),
        .pop_ready    (pop_ready),
        .pop_item     (pop_item),
        .div_req      (div_req),
        .div_rsp      (div_rsp),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    // Compute the window rate when a full window closes
    orhm_rate_div u_rate_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

endmodule
